// ===== hw/rtl/bewh_pkg.sv =====
// shared types, constants and helpers for the beta event window histogrammer
// depends on nothing; imported by bewh_cfg, bewh_classify and the top level
package bewh_pkg;

    localparam int FREQ_BINS  = 8192;
    localparam int COUNT_BITS = 32;
    localparam int ADDR_W     = $clog2(FREQ_BINS);
    localparam int BIN_W      = 13;
    localparam int WIN_NUM    = 6;

    localparam logic [15:0] GATE_LOW     = 16'd32769;
    localparam logic [15:0] NMR_ON_HIGH  = 16'd38943;
    localparam logic [15:0] NMR_OFF_HIGH = 16'd38804;
    localparam logic [15:0] NQR_ON_HIGH  = 16'd39494;
    localparam logic [15:0] NQR_OFF_HIGH = 16'd38894;
    localparam logic [BIN_W-1:0] NMR_OFF_BIN = 13'd2530;
    localparam logic [BIN_W-1:0] NQR_OFF_BIN = 13'd4400;
    localparam logic [7:0]  BAD_FLAG     = 8'd100;
    localparam logic [BIN_W-1:0] MIN_BIN = 13'd50;

    localparam logic [2:0] REG_NQR_MODE     = 3'd0;
    localparam logic [2:0] REG_FIELD_REQ    = 3'd1;
    localparam logic [2:0] REG_TAC_UP       = 3'd2;
    localparam logic [2:0] REG_ENERGY_UP    = 3'd3;
    localparam logic [2:0] REG_DELTA_UP     = 3'd4;
    localparam logic [2:0] REG_TAC_DN       = 3'd5;
    localparam logic [2:0] REG_ENERGY_DOWN  = 3'd6;
    localparam logic [2:0] REG_DELTA_DOWN   = 3'd7;

    typedef enum logic {
        CMD_EVENT = 1'b0,
        CMD_READ  = 1'b1
    } t_cmd;

    typedef enum logic [2:0] {
        CLS_SKIP    = 3'd0,
        CLS_NOGATE  = 3'd1,
        CLS_BOTH    = 3'd2,
        CLS_UP      = 3'd3,
        CLS_DOWN    = 3'd4,
        CLS_NEITHER = 3'd5,
        CLS_READ    = 3'd6
    } t_class;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_UPDATE
    } t_state;

    typedef struct packed {
        logic                       nqr_mode;
        logic                       field_required;
        logic [WIN_NUM-1:0][31:0]   win;
    } t_cfg;

    typedef struct packed {
        t_class             cls;
        logic [BIN_W-1:0]   bin;
        logic               go_up;
        logic               go_down;
        logic               report;
        logic               in_range;
    } t_dec;

    typedef struct packed {
        logic                   seen;
        logic [COUNT_BITS-1:0]  down;
        logic [COUNT_BITS-1:0]  up;
    } t_entry;

    function automatic logic [COUNT_BITS-1:0] sat_inc(input logic [COUNT_BITS-1:0] c);
        return (c == {COUNT_BITS{1'b1}}) ? c : c + 1'b1;
    endfunction

    function automatic logic [31:0] to32(input logic [COUNT_BITS-1:0] c);
        logic [63:0] w;
        w = 64'(c);
        return w[31:0];
    endfunction

endpackage

// ===== hw/rtl/bewh_hist_ram.sv =====
// generic single-write, single-read synchronous ram with registered read data
// depends on nothing
module bewh_hist_ram #(
    parameter int DEPTH = 8192,
    parameter int WIDTH = 65,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hw/rtl/bewh_cfg.sv =====
// apb register file: mode, field check and the six telescope windows
// depends on bewh_pkg
module bewh_cfg
    import bewh_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    output t_cfg        o_cfg
);

    t_cfg       r_cfg;
    logic       wr;
    logic [2:0] idx;

    assign pready = 1'b1;
    assign wr     = psel & penable & pwrite;
    assign idx    = paddr[4:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (wr) begin
            unique case (idx)
                REG_NQR_MODE:  r_cfg.nqr_mode       <= pwdata[0];
                REG_FIELD_REQ: r_cfg.field_required <= pwdata[0];
                default:       r_cfg.win[idx - REG_TAC_UP] <= pwdata;
            endcase
        end
    end

    always_comb begin
        unique case (idx)
            REG_NQR_MODE:  prdata = {31'd0, r_cfg.nqr_mode};
            REG_FIELD_REQ: prdata = {31'd0, r_cfg.field_required};
            default:       prdata = r_cfg.win[idx - REG_TAC_UP];
        endcase
    end

    assign o_cfg = r_cfg;

endmodule

// ===== hw/rtl/bewh_classify.sv =====
// command decode: bin reads, skip check, rf gate bin choice and telescope windows
// depends on bewh_pkg
module bewh_classify
    import bewh_pkg::*;
(
    input  t_cfg              i_cfg,
    input  logic              i_command,
    input  logic [7:0]        i_event_flag,
    input  logic [15:0]       i_field_whole,
    input  logic [15:0]       i_rf_on_gate,
    input  logic [15:0]       i_rf_off_gate,
    input  logic [BIN_W-1:0]  i_rf_frequency,
    input  logic [WIN_NUM-1:0][15:0] i_tel,
    output t_dec              o_dec
);

    logic [WIN_NUM-1:0] hit;
    logic [15:0]        on_hi;
    logic [15:0]        off_hi;
    logic [BIN_W-1:0]   off_bin;
    logic               on_ok;
    logic               off_ok;
    logic [BIN_W-1:0]   bin;
    logic               in_range;
    logic               up_ok;
    logic               dn_ok;

    always_comb begin
        for (int k = 0; k < WIN_NUM; k++) begin
            hit[k] = (i_tel[k] > i_cfg.win[k][15:0]) && (i_tel[k] < i_cfg.win[k][31:16]);
        end
    end

    assign on_hi   = i_cfg.nqr_mode ? NQR_ON_HIGH  : NMR_ON_HIGH;
    assign off_hi  = i_cfg.nqr_mode ? NQR_OFF_HIGH : NMR_OFF_HIGH;
    assign off_bin = i_cfg.nqr_mode ? NQR_OFF_BIN  : NMR_OFF_BIN;
    assign on_ok   = (i_rf_on_gate  > GATE_LOW) && (i_rf_on_gate  < on_hi);
    assign off_ok  = (i_rf_off_gate > GATE_LOW) && (i_rf_off_gate < off_hi);
    assign bin     = off_ok ? off_bin : (on_ok ? i_rf_frequency : '0);
    assign up_ok   = hit[0] & hit[1] & hit[2];
    assign dn_ok   = hit[3] & hit[4] & hit[5];

    always_comb begin
        o_dec          = '0;
        o_dec.cls      = CLS_SKIP;
        in_range       = 1'b0;
        priority if (i_command == CMD_READ) begin
            o_dec.cls      = CLS_READ;
            o_dec.bin      = i_rf_frequency;
            o_dec.report   = 1'b1;
            o_dec.in_range = 17'(i_rf_frequency) < 17'(FREQ_BINS);
        end else if (i_event_flag == BAD_FLAG ||
                     (i_cfg.field_required && i_field_whole == '0)) begin
            o_dec.cls = CLS_SKIP;
        end else begin
            in_range  = 17'(bin) < 17'(FREQ_BINS);
            o_dec.bin = bin;
            if (bin < MIN_BIN || !in_range) begin
                o_dec.cls = CLS_NOGATE;
            end else begin
                o_dec.report   = 1'b1;
                o_dec.in_range = 1'b1;
                o_dec.go_up    = up_ok;
                o_dec.go_down  = dn_ok;
                if (up_ok && dn_ok) begin
                    o_dec.cls = CLS_BOTH;
                end else if (up_ok) begin
                    o_dec.cls = CLS_UP;
                end else if (dn_ok) begin
                    o_dec.cls = CLS_DOWN;
                end else begin
                    o_dec.cls = CLS_NEITHER;
                end
            end
        end
    end

endmodule

// ===== hw/rtl/beta_event_window_histogrammer.sv =====
// top level of the beta event window histogrammer: stream ports, apb port,
// bin ram clear and read-modify-write sequencing
// depends on bewh_pkg, bewh_cfg, bewh_classify, bewh_hist_ram
//
// usage:
//   s_axis carries one transaction per event or bin read; tuser selects the
//   command, tdata holds the event fields. m_axis returns exactly one result
//   transaction per input, tuser holding the event class.
//   an event is decoded as it is accepted and the bin entry is read from the
//   histogram ram; in the update state, once the output register is free, the
//   entry of an up, down or neither event is updated and written back and the
//   result enters the output register. no new item is taken until the last
//   has made its single read-then-write pass over the one-port-pair bin ram.
//   after reset the ram is cleared one bin per cycle over all FREQ_BINS bins
//   (8192), with s_axis_tready low; apb writes are taken throughout.
//   when the receiver stalls, the result waits in the output register; one
//   further item is accepted and then waits in the update state until the
//   output register frees.
//   the user must write configuration over apb only while the block is idle; the block itself does not enforce this.
module beta_event_window_histogrammer
    import bewh_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // event_flag, field_whole, rf_on_gate, rf_off_gate, rf_frequency, tac_up,
    // energy_up, delta_up, tac_dn, energy_down, delta_down, zero fill
    input  logic [167:0] s_axis_tdata,
    // command
    input  logic [0:0]   s_axis_tuser,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // selected_bin, up_count, down_count, bin_seen, coincidence_count, zero fill
    output logic [111:0] m_axis_tdata,
    // event_class
    output logic [2:0]   m_axis_tuser,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [4:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);

    localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(FREQ_BINS - 1);

    t_cfg                   cfg;
    t_dec                   dec;
    t_state                 r_state, n_state;
    logic [ADDR_W-1:0]      r_clr_addr;
    t_dec                   r_dec;
    logic [COUNT_BITS-1:0]  r_coinc;
    logic                   r_out_valid;
    t_class                 r_out_class;
    logic [111:0]           r_out_data;
    logic [WIN_NUM-1:0][15:0] tel;
    logic                   accept;
    logic                   out_free;
    logic                   advance;
    logic                   ram_we;
    logic [ADDR_W-1:0]      ram_waddr;
    t_entry                 ram_wdata;
    t_entry                 rd_entry;
    t_entry                 new_entry;
    logic [COUNT_BITS-1:0]  n_coinc;
    logic                   write_bin;

    bewh_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    assign tel[0] = s_axis_tdata[84:69];
    assign tel[1] = s_axis_tdata[100:85];
    assign tel[2] = s_axis_tdata[116:101];
    assign tel[3] = s_axis_tdata[132:117];
    assign tel[4] = s_axis_tdata[148:133];
    assign tel[5] = s_axis_tdata[164:149];

    bewh_classify u_classify (
        .i_cfg          (cfg),
        .i_command      (s_axis_tuser[0]),
        .i_event_flag   (s_axis_tdata[7:0]),
        .i_field_whole  (s_axis_tdata[23:8]),
        .i_rf_on_gate   (s_axis_tdata[39:24]),
        .i_rf_off_gate  (s_axis_tdata[55:40]),
        .i_rf_frequency (s_axis_tdata[68:56]),
        .i_tel          (tel),
        .o_dec          (dec)
    );

    bewh_hist_ram #(
        .DEPTH (FREQ_BINS),
        .WIDTH ($bits(t_entry)),
        .AW    (ADDR_W)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (accept),
        .i_raddr (ADDR_W'(dec.bin)),
        .o_rdata (rd_entry)
    );

    assign s_axis_tready = (r_state == ST_IDLE);
    assign accept        = s_axis_tvalid & s_axis_tready;
    assign out_free      = !r_out_valid || m_axis_tready;
    assign advance       = (r_state == ST_UPDATE) && out_free;
    assign write_bin     = (r_dec.cls == CLS_UP) || (r_dec.cls == CLS_DOWN) ||
                           (r_dec.cls == CLS_NEITHER);

    always_comb begin
        new_entry = rd_entry;
        if (write_bin) begin
            new_entry.seen = 1'b1;
            if (r_dec.go_up) begin
                new_entry.up = sat_inc(rd_entry.up);
            end
            if (r_dec.go_down) begin
                new_entry.down = sat_inc(rd_entry.down);
            end
        end
        if (!(r_dec.report && r_dec.in_range)) begin
            new_entry = '0;
        end
        n_coinc = (r_dec.cls == CLS_BOTH) ? sat_inc(r_coinc) : r_coinc;
    end

    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = r_clr_addr;
        ram_wdata = '0;
        if (r_state == ST_CLEAR) begin
            ram_we = 1'b1;
        end else if (advance && write_bin) begin
            ram_we    = 1'b1;
            ram_waddr = ADDR_W'(r_dec.bin);
            ram_wdata = new_entry;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_CLEAR:  if (r_clr_addr == LAST_ADDR) n_state = ST_IDLE;
            ST_IDLE:   if (accept) n_state = ST_UPDATE;
            ST_UPDATE: if (out_free) n_state = ST_IDLE;
            default:   n_state = ST_CLEAR;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_clr_addr  <= '0;
            r_coinc     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == ST_CLEAR) begin
                r_clr_addr <= r_clr_addr + 1'b1;
            end
            if (advance) begin
                r_coinc     <= n_coinc;
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_dec <= dec;
        end
        if (advance) begin
            r_out_class <= r_dec.cls;
            r_out_data  <= {2'b00, to32(n_coinc), new_entry.seen, to32(new_entry.down),
                            to32(new_entry.up), r_dec.bin};
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tuser  = r_out_class;

endmodule
